// ===== hw/rtl/core_mask_backfill_scheduler_assert.svh =====
// Assertion macros for the backfill scheduler.
`ifndef CORE_MASK_BACKFILL_SCHEDULER_ASSERT_SVH
`define CORE_MASK_BACKFILL_SCHEDULER_ASSERT_SVH
// ante holds -> cons holds in the same cycle
`define CMBS_AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler assertion failed");
// ante holds -> cons holds in the next cycle
`define CMBS_AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler assertion failed");
`endif

// ===== hw/rtl/cmbs_pkg.sv =====
// Shared types and codes of the backfill scheduler.
package cmbs_pkg;
	localparam logic [1:0] ACT_OFFER   = 2'd0;
	localparam logic [1:0] ACT_BEGIN   = 2'd1;
	localparam logic [1:0] ACT_FINISH  = 2'd2;
	localparam logic [1:0] ACT_OVERDUE = 2'd3;

	localparam logic [2:0] KIND_STARTED  = 3'd0;
	localparam logic [2:0] KIND_RESERVED = 3'd1;
	localparam logic [2:0] KIND_WAITING  = 3'd2;
	localparam logic [2:0] KIND_RELEASED = 3'd3;
	localparam logic [2:0] KIND_OVERDUE  = 3'd4;
	localparam logic [2:0] KIND_NOTHING  = 3'd5;

	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 104;

	typedef struct packed {
		logic       take;
		logic       start_ld;
		logic       start_resv;
		logic       upd;
		logic       walk_step;
		logic       commit;
		logic       reserve;
		logic       emit_k;
		logic [2:0] emit_kind;
		logic       rel_rd;
		logic       rel_commit;
		logic       scan_init;
		logic       scan_step;
		logic       scan_fin;
	} cmd_t;

	typedef struct packed {
		logic [1:0] act;
		logic       fits_in;
		logic       fits_resv;
		logic       bf_ok;
		logic       resv_v;
		logic       rel_ok;
		logic       walk_end;
		logic       scan_end;
		logic       hit;
		logic       pend_v;
		logic       out_free;
	} st_t;
endpackage

// ===== hw/rtl/cmbs_ram.sv =====
// Generic single-write, single-read RAM with registered read.
module cmbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== hw/rtl/cmbs_ctrl.sv =====
// Controller state machine of the backfill scheduler.
module cmbs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cmbs_pkg::st_t st,
	output cmbs_pkg::cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_WALK = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;
	localparam logic [2:0] S_REL  = 3'd4;
	localparam logic [2:0] S_SCAN = 3'd5;
	localparam logic [2:0] S_SEND = 3'd6;

	logic [2:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.emit_kind = cmbs_pkg::KIND_NOTHING;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				case (st.act)
					cmbs_pkg::ACT_OFFER: begin
						if (!st.resv_v && st.fits_in) begin
							cmd.start_ld = 1'b1;
							cmd.upd = 1'b1;
							state_d = S_WALK;
						end else if (st.resv_v && st.bf_ok && st.fits_in) begin
							cmd.start_ld = 1'b1;
							state_d = S_WALK;
						end else if (st.out_free) begin
							if (!st.resv_v) begin
								cmd.reserve = 1'b1;
							end else begin
								cmd.emit_k = 1'b1;
								cmd.emit_kind = cmbs_pkg::KIND_WAITING;
							end
							state_d = S_IDLE;
						end
					end
					cmbs_pkg::ACT_BEGIN: begin
						if (st.resv_v && st.fits_resv) begin
							cmd.start_ld = 1'b1;
							cmd.start_resv = 1'b1;
							cmd.upd = 1'b1;
							state_d = S_WALK;
						end else if (st.out_free) begin
							cmd.emit_k = 1'b1;
							state_d = S_IDLE;
						end
					end
					cmbs_pkg::ACT_FINISH: begin
						if (st.rel_ok) begin
							cmd.rel_rd = 1'b1;
							state_d = S_REL;
						end else if (st.out_free) begin
							cmd.emit_k = 1'b1;
							state_d = S_IDLE;
						end
					end
					default: begin
						cmd.scan_init = 1'b1;
						state_d = S_SCAN;
					end
				endcase
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (st.walk_end) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_REL: begin
				if (st.out_free) begin
					cmd.rel_commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if (!(st.hit && st.pend_v && !st.out_free)) begin
					cmd.scan_step = 1'b1;
					if (st.scan_end) begin
						state_d = S_SEND;
					end
				end
			end
			S_SEND: begin
				if (st.out_free) begin
					cmd.scan_fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== hw/rtl/cmbs_dp.sv =====
// Datapath of the backfill scheduler: core and slot state, slot RAM, result register.
module cmbs_dp #(
	parameter int NUM_CORES = 64,
	parameter int NUM_SLOTS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [1:0]                        in_action,
	input  logic [cmbs_pkg::IN_DATA_W-1:0]    in_data,
	input  cmbs_pkg::cmd_t                    cmd,
	output cmbs_pkg::st_t                     st,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        out_kind,
	output logic [cmbs_pkg::OUT_DATA_W-1:0]   out_data,
	output logic                              out_last
);
	localparam int USED = (NUM_SLOTS > 64) ? 64 : NUM_SLOTS;
	localparam int SW   = (USED > 1) ? $clog2(USED) : 1;
	localparam int CW   = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
	localparam int WALK = (NUM_CORES > USED) ? NUM_CORES : USED;
	localparam int IW   = $clog2(WALK + 1);
	localparam int RW   = 7 + 33 + NUM_CORES;

	logic [1:0]           act_q;
	logic [6:0]           cores_q;
	logic [31:0]          limit_q;
	logic [31:0]          now_q;
	logic [5:0]           slot_q;

	logic [NUM_CORES-1:0] free_mask_q;
	logic [6:0]           free_cnt_q;
	logic [USED-1:0]      valid_q;
	logic [32:0]          latest_q;
	logic                 resv_v_q;
	logic [6:0]           resv_cores_q;
	logic [31:0]          resv_limit_q;
	logic [32:0]          resv_time_q;

	logic [SW-1:0]        slot_new_q;
	logic [32:0]          end_new_q;
	logic [6:0]           need_q;
	logic                 upd_q;
	logic [NUM_CORES-1:0] mask_acc_q;
	logic [6:0]           taken_q;
	logic [32:0]          lat_acc_q;
	logic [IW-1:0]        idx_q;
	logic [SW-1:0]        rd_idx_s1;
	logic                 rd_v_s1;

	logic                 pend_v_q;
	logic [SW-1:0]        pend_slot_q;
	logic [NUM_CORES-1:0] pend_mask_q;
	logic [32:0]          pend_end_q;

	logic                 out_valid_q;
	logic [2:0]           out_kind_q;
	logic [5:0]           out_slot_q;
	logic [63:0]          out_mask_q;
	logic [32:0]          out_end_q;
	logic                 out_last_q;

	logic                 any_free;
	logic [SW-1:0]        first_free;
	logic                 ram_we;
	logic                 ram_re;
	logic [SW-1:0]        ram_raddr;
	logic [RW-1:0]        ram_wdata;
	logic [RW-1:0]        ram_rdata;
	logic [NUM_CORES-1:0] rd_mask;
	logic [32:0]          rd_end;
	logic [6:0]           rd_cnt;
	logic                 idx_in_slots;
	logic                 idx_in_cores;
	logic                 hit;
	logic                 out_free;
	logic [6:0]           start_need;
	logic [31:0]          start_limit;

	always_comb begin
		any_free = 1'b0;
		first_free = '0;
		for (int i = USED - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				any_free = 1'b1;
				first_free = SW'(i);
			end
		end
	end

	assign rd_mask = ram_rdata[NUM_CORES-1:0];
	assign rd_end  = ram_rdata[NUM_CORES+32:NUM_CORES];
	assign rd_cnt  = ram_rdata[RW-1:NUM_CORES+33];

	assign idx_in_slots = (idx_q < IW'(USED));
	assign idx_in_cores = (idx_q < IW'(NUM_CORES));
	assign hit = rd_v_s1 && valid_q[rd_idx_s1] && (rd_end < {1'b0, now_q});
	assign out_free = !out_valid_q || out_ready;

	assign ram_re = cmd.rel_rd || ((cmd.walk_step || cmd.scan_step) && idx_in_slots);
	assign ram_raddr = cmd.rel_rd ? slot_q[SW-1:0] : idx_q[SW-1:0];
	assign ram_we = cmd.commit;
	assign ram_wdata = {need_q, end_new_q, mask_acc_q};

	assign start_need  = cmd.start_resv ? resv_cores_q : cores_q;
	assign start_limit = cmd.start_resv ? resv_limit_q : limit_q;

	cmbs_ram #(
		.WIDTH(RW),
		.DEPTH(USED)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_new_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		st = '0;
		st.act       = act_q;
		st.fits_in   = (cores_q <= free_cnt_q) && any_free;
		st.fits_resv = (resv_cores_q <= free_cnt_q) && any_free;
		st.bf_ok     = (({1'b0, now_q} + {1'b0, limit_q}) < resv_time_q);
		st.resv_v    = resv_v_q;
		st.rel_ok    = ({1'b0, slot_q} < 7'(USED)) && valid_q[slot_q[SW-1:0]];
		st.walk_end  = (idx_q == IW'(WALK));
		st.scan_end  = (idx_q == IW'(USED));
		st.hit       = hit;
		st.pend_v    = pend_v_q;
		st.out_free  = out_free;
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			act_q   <= in_action;
			cores_q <= in_data[6:0];
			limit_q <= in_data[38:7];
			now_q   <= in_data[70:39];
			slot_q  <= in_data[76:71];
		end
		if (cmd.start_ld) begin
			slot_new_q <= first_free;
			end_new_q  <= {1'b0, now_q} + {1'b0, start_limit};
			lat_acc_q  <= {1'b0, now_q} + {1'b0, start_limit};
			need_q     <= start_need;
			upd_q      <= cmd.upd;
			mask_acc_q <= '0;
			taken_q    <= '0;
		end
		if (cmd.walk_step) begin
			if (idx_in_cores && free_mask_q[idx_q[CW-1:0]] && (taken_q < need_q)) begin
				mask_acc_q[idx_q[CW-1:0]] <= 1'b1;
				taken_q <= taken_q + 7'd1;
			end
			if (rd_v_s1 && valid_q[rd_idx_s1] && (rd_end > lat_acc_q)) begin
				lat_acc_q <= rd_end;
			end
		end
		if (cmd.scan_step && hit) begin
			pend_slot_q <= rd_idx_s1;
			pend_mask_q <= rd_mask;
			pend_end_q  <= rd_end;
		end
		if (cmd.walk_step || cmd.scan_step) begin
			rd_idx_s1 <= idx_q[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_mask_q  <= '1;
			free_cnt_q   <= 7'(NUM_CORES);
			valid_q      <= '0;
			latest_q     <= '0;
			resv_v_q     <= 1'b0;
			resv_cores_q <= '0;
			resv_limit_q <= '0;
			resv_time_q  <= '0;
			idx_q        <= '0;
			rd_v_s1      <= 1'b0;
			pend_v_q     <= 1'b0;
		end else begin
			if (cmd.start_ld) begin
				idx_q   <= '0;
				rd_v_s1 <= 1'b0;
				if (cmd.start_resv) begin
					resv_v_q <= 1'b0;
				end
			end
			if (cmd.scan_init) begin
				idx_q    <= '0;
				rd_v_s1  <= 1'b0;
				pend_v_q <= 1'b0;
			end
			if (cmd.walk_step || cmd.scan_step) begin
				idx_q   <= idx_q + IW'(1);
				rd_v_s1 <= idx_in_slots;
			end
			if (cmd.scan_step && hit) begin
				pend_v_q <= 1'b1;
			end
			if (cmd.commit) begin
				valid_q[slot_new_q] <= 1'b1;
				free_mask_q <= free_mask_q & ~mask_acc_q;
				free_cnt_q  <= free_cnt_q - need_q;
				if (upd_q) begin
					latest_q <= lat_acc_q;
				end
			end
			if (cmd.reserve) begin
				resv_v_q     <= 1'b1;
				resv_cores_q <= cores_q;
				resv_limit_q <= limit_q;
				resv_time_q  <= latest_q;
			end
			if (cmd.rel_commit) begin
				valid_q[slot_q[SW-1:0]] <= 1'b0;
				free_mask_q <= free_mask_q | rd_mask;
				free_cnt_q  <= free_cnt_q + rd_cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit || cmd.reserve || cmd.emit_k || cmd.rel_commit
				|| cmd.scan_fin || (cmd.scan_step && hit && pend_v_q)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_kind_q <= cmbs_pkg::KIND_STARTED;
			out_slot_q <= 6'(slot_new_q);
			out_mask_q <= 64'(mask_acc_q);
			out_end_q  <= end_new_q;
			out_last_q <= 1'b1;
		end else if (cmd.reserve) begin
			out_kind_q <= cmbs_pkg::KIND_RESERVED;
			out_slot_q <= '0;
			out_mask_q <= '0;
			out_end_q  <= latest_q;
			out_last_q <= 1'b1;
		end else if (cmd.rel_commit) begin
			out_kind_q <= cmbs_pkg::KIND_RELEASED;
			out_slot_q <= slot_q;
			out_mask_q <= 64'(rd_mask);
			out_end_q  <= '0;
			out_last_q <= 1'b1;
		end else if ((cmd.scan_step && hit && pend_v_q) || (cmd.scan_fin && pend_v_q)) begin
			out_kind_q <= cmbs_pkg::KIND_OVERDUE;
			out_slot_q <= 6'(pend_slot_q);
			out_mask_q <= 64'(pend_mask_q);
			out_end_q  <= pend_end_q;
			out_last_q <= cmd.scan_fin;
		end else if (cmd.emit_k || cmd.scan_fin) begin
			out_kind_q <= cmd.emit_k ? cmd.emit_kind : cmbs_pkg::KIND_NOTHING;
			out_slot_q <= '0;
			out_mask_q <= '0;
			out_end_q  <= '0;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_data  = {1'b0, out_end_q, out_mask_q, out_slot_q};
	assign out_last  = out_last_q;
endmodule

// ===== hw/rtl/core_mask_backfill_scheduler.sv =====
// Top level of the backfill job scheduler over a free-core mask.
// One item is taken at a time. Reserve, wait, and a begin or finish with nothing to do
// are settled in the decode state; a finish that releases a slot reads the slot RAM
// first. Starting a job walks over the core bits once, picking the lowest free cores
// while the slot RAM is read once per slot to recompute the latest end time. An overdue
// scan reads one slot RAM entry per cycle, holding while the result side stalls. Results
// leave through a one-beat output register.
module core_mask_backfill_scheduler #(
	parameter int NUM_CORES = 64,
	parameter int NUM_SLOTS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [cmbs_pkg::IN_DATA_W-1:0]    s_tdata,  // cores, limit, now, slot
	input  logic [1:0]                        s_tuser,  // action
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [cmbs_pkg::OUT_DATA_W-1:0]   m_tdata,  // job_slot, mask, end
	output logic [2:0]                        m_tuser,  // kind
	output logic                              m_tlast
);
	`include "core_mask_backfill_scheduler_assert.svh"

	cmbs_pkg::cmd_t cmd;
	cmbs_pkg::st_t  st;
	logic           emit_any;

	cmbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	cmbs_dp #(
		.NUM_CORES(NUM_CORES),
		.NUM_SLOTS(NUM_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_action (s_tuser),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.st        (st),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

	assign emit_any = cmd.commit || cmd.reserve || cmd.emit_k || cmd.rel_commit
		|| cmd.scan_fin;

	`CMBS_AST_IMP(a_emit_free, emit_any, st.out_free)
	`CMBS_AST_NXT(a_one_item, (s_tvalid && s_tready), !s_tready)
	`CMBS_AST_IMP(a_start_fits, cmd.start_ld, (st.fits_in || st.fits_resv))
endmodule

// ===== verif/core_mask_backfill_scheduler_chk.sv =====
// Checker that predicts and compares the scheduler's result beats.
module core_mask_backfill_scheduler_chk (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [cmbs_pkg::IN_DATA_W-1:0]    s_tdata,  // cores, limit, now, slot
	input  logic [1:0]                        s_tuser,  // action
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [cmbs_pkg::OUT_DATA_W-1:0]   m_tdata,  // job_slot, mask, end
	input  logic [2:0]                        m_tuser,  // kind
	input  logic                              m_tlast,
	output int                                fail_count,
	output int                                pending
);
	typedef struct packed {
		logic [2:0]  kind;
		logic [5:0]  job_slot;
		logic [63:0] granted;
		logic [32:0] finish_at;
		logic        last;
	} sched_beat_t;

	sched_beat_t expected_beats[$];

	logic [63:0] free_mask;
	logic        slot_busy[64];
	logic [63:0] slot_cores[64];
	logic [32:0] slot_end[64];
	logic [32:0] latest_end;
	logic        resv_held;
	logic [6:0]  resv_cores;
	logic [32:0] resv_time;
	logic [31:0] resv_limit;

	function automatic int lowest_idle_slot();
		for (int i = 0; i < 64; i++)
			if (!slot_busy[i])
				return i;
		return -1;
	endfunction

	function automatic bit job_fits(logic [6:0] c);
		return c <= $countones(free_mask) && lowest_idle_slot() >= 0;
	endfunction

	function automatic sched_beat_t mk(logic [2:0] k, logic [5:0] s, logic [63:0] m,
			logic [32:0] e, logic l);
		sched_beat_t b;
		b.kind = k;
		b.job_slot = s;
		b.granted = m;
		b.finish_at = e;
		b.last = l;
		return b;
	endfunction

	function automatic void queue_beat(sched_beat_t b);
		expected_beats.insert(expected_beats.size(), b);
	endfunction

	task automatic launch_job(logic [6:0] c, logic [31:0] lim, logic [31:0] now, bit upd);
		int s;
		logic [63:0] m;
		int taken;
		s = lowest_idle_slot();
		m = '0;
		taken = 0;
		for (int b = 0; b < 64; b++)
			if (taken < c && free_mask[b]) begin
				m[b] = 1'b1;
				taken++;
			end
		free_mask ^= m;
		slot_busy[s] = 1'b1;
		slot_cores[s] = m;
		slot_end[s] = {1'b0, now} + {1'b0, lim};
		if (upd) begin
			latest_end = '0;
			for (int i = 0; i < 64; i++)
				if (slot_busy[i] && slot_end[i] > latest_end)
					latest_end = slot_end[i];
		end
		queue_beat(mk(cmbs_pkg::KIND_STARTED, s[5:0], m, slot_end[s], 1'b1));
	endtask

	task automatic predict(logic [1:0] act, logic [79:0] d);
		logic [6:0]  c;
		logic [31:0] lim;
		logic [31:0] now;
		logic [5:0]  s;
		int n;
		int k;
		c = d[6:0];
		lim = d[38:7];
		now = d[70:39];
		s = d[76:71];
		case (act)
			cmbs_pkg::ACT_OFFER: begin
				if (!resv_held) begin
					if (job_fits(c))
						launch_job(c, lim, now, 1'b1);
					else begin
						resv_held = 1'b1;
						resv_cores = c;
						resv_limit = lim;
						resv_time = latest_end;
						queue_beat(mk(cmbs_pkg::KIND_RESERVED, 0, 0, resv_time, 1'b1));
					end
				end else if ({1'b0, now} + {1'b0, lim} < resv_time && job_fits(c))
					launch_job(c, lim, now, 1'b0);
				else
					queue_beat(mk(cmbs_pkg::KIND_WAITING, 0, 0, 0, 1'b1));
			end
			cmbs_pkg::ACT_BEGIN: begin
				if (resv_held && job_fits(resv_cores)) begin
					launch_job(resv_cores, resv_limit, now, 1'b1);
					resv_held = 1'b0;
				end else
					queue_beat(mk(cmbs_pkg::KIND_NOTHING, 0, 0, 0, 1'b1));
			end
			cmbs_pkg::ACT_FINISH: begin
				if (slot_busy[s]) begin
					free_mask |= slot_cores[s];
					slot_busy[s] = 1'b0;
					queue_beat(mk(cmbs_pkg::KIND_RELEASED, s, slot_cores[s], 0, 1'b1));
				end else
					queue_beat(mk(cmbs_pkg::KIND_NOTHING, 0, 0, 0, 1'b1));
			end
			default: begin
				n = 0;
				for (int i = 0; i < 64; i++)
					if (slot_busy[i] && slot_end[i] < {1'b0, now})
						n++;
				if (n == 0)
					queue_beat(mk(cmbs_pkg::KIND_NOTHING, 0, 0, 0, 1'b1));
				else begin
					k = 0;
					for (int i = 0; i < 64; i++)
						if (slot_busy[i] && slot_end[i] < {1'b0, now}) begin
							k++;
							queue_beat(mk(cmbs_pkg::KIND_OVERDUE, i[5:0], slot_cores[i],
								slot_end[i], k == n));
						end
				end
			end
		endcase
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		free_mask = '1;
		latest_end = '0;
		resv_held = 1'b0;
		resv_cores = '0;
		resv_time = '0;
		resv_limit = '0;
		for (int i = 0; i < 64; i++) begin
			slot_busy[i] = 1'b0;
			slot_cores[i] = '0;
			slot_end[i] = '0;
		end
	end

	always @(posedge clk) begin
		sched_beat_t got;
		sched_beat_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = mk(m_tuser, m_tdata[5:0], m_tdata[69:6], m_tdata[102:70], m_tlast);
				if (expected_beats.size() == 0) begin
					$display("%0t: expected no beat, actual %h", $time, got);
					fail_count++;
				end else begin
					want = expected_beats.pop_front();
					if (got !== want) begin
						$display("%0t: expected kind %0d slot %0d mask %h end %h last %b",
							$time, want.kind, want.job_slot, want.granted, want.finish_at,
							want.last);
						$display("%0t: actual   kind %0d slot %0d mask %h end %h last %b",
							$time, got.kind, got.job_slot, got.granted, got.finish_at,
							got.last);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				predict(s_tuser, s_tdata);
			pending = expected_beats.size();
		end
	end
endmodule

// ===== verif/core_mask_backfill_scheduler_tb.sv =====
// Testbench top: stimulus, stalls and verdict for the backfill scheduler.
module core_mask_backfill_scheduler_tb;
	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [cmbs_pkg::IN_DATA_W-1:0]  s_tdata;
	logic [1:0]                      s_tuser;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [cmbs_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [2:0]                      m_tuser;
	logic                            m_tlast;
	int                              fail_count;
	int                              pending;
	int                              send_idle_pct;
	int                              recv_idle_pct;
	logic [31:0]                     clock_now;

	core_mask_backfill_scheduler u_dut (.*);

	core_mask_backfill_scheduler_chk u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("core_mask_backfill_scheduler: mismatch");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= $urandom_range(99) >= recv_idle_pct;
	end

	task automatic send_job(logic [1:0] act, logic [6:0] c, logic [31:0] lim,
			logic [31:0] now, logic [5:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {3'b0, s, now, lim, c};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic rand_job();
		int r;
		logic [31:0] lim;
		logic [6:0]  c;
		logic [31:0] now;
		r = int'($urandom_range(99));
		lim = ($urandom_range(3) == 0) ? $urandom : $urandom_range(200);
		clock_now = clock_now + $urandom_range(20);
		c = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(12));
		if (r < 45) begin
			now = ($urandom_range(15) == 0) ? $urandom : clock_now;
			send_job(cmbs_pkg::ACT_OFFER, c, lim, now, 6'($urandom));
		end else if (r < 60)
			send_job(cmbs_pkg::ACT_BEGIN, c, lim, clock_now, 6'($urandom));
		else if (r < 88)
			send_job(cmbs_pkg::ACT_FINISH, c, lim, $urandom, 6'($urandom_range(15)));
		else begin
			now = ($urandom_range(7) == 0) ? $urandom : clock_now;
			send_job(cmbs_pkg::ACT_OVERDUE, c, lim, now, 6'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = cmbs_pkg::ACT_OFFER;
		send_idle_pct = 37;
		recv_idle_pct = 48;
		clock_now = 100;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_job(cmbs_pkg::ACT_BEGIN, 0, 0, 0, 0);
		send_job(cmbs_pkg::ACT_FINISH, 0, 0, 0, 0);
		send_job(cmbs_pkg::ACT_OVERDUE, 0, 0, '1, 0);
		send_job(cmbs_pkg::ACT_OFFER, 0, 5, 10, 0);
		send_job(cmbs_pkg::ACT_OFFER, 7'd64, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_job(cmbs_pkg::ACT_OFFER, 7'd100, 0, 0, 0);
		send_job(cmbs_pkg::ACT_OFFER, 1, 1, 0, 0);
		send_job(cmbs_pkg::ACT_OFFER, 1, 1, 32'hFFFF_FFFF, 0);
		send_job(cmbs_pkg::ACT_OVERDUE, 0, 0, '1, 0);
		send_job(cmbs_pkg::ACT_BEGIN, 0, 0, 0, 0);
		send_job(cmbs_pkg::ACT_FINISH, 0, 0, 0, 6'd63);
		send_job(cmbs_pkg::ACT_FINISH, 0, 0, 0, 6'd1);
		send_job(cmbs_pkg::ACT_FINISH, 0, 0, 0, 6'd0);
		send_job(cmbs_pkg::ACT_BEGIN, 0, 0, 0, 0);
		send_job(cmbs_pkg::ACT_BEGIN, 0, 0, 0, 0);
		for (int i = 0; i < 64; i++)
			send_job(cmbs_pkg::ACT_OFFER, 0, i, 32'd1000, 0);
		send_job(cmbs_pkg::ACT_OFFER, 0, 1, 0, 0);
		send_job(cmbs_pkg::ACT_OVERDUE, 0, 0, '1, 0);
		for (int i = 0; i < 64; i++)
			send_job(cmbs_pkg::ACT_FINISH, 0, 0, 0, i[5:0]);
		send_job(cmbs_pkg::ACT_OFFER, 0, 0, 0, 0);
		for (int i = 0; i < 264; i++) begin
			if (i == 40) begin
				send_idle_pct = 48;
				recv_idle_pct = 37;
			end
			if (i == 150) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			rand_job();
		end
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("core_mask_backfill_scheduler: match");
		else
			$display("core_mask_backfill_scheduler: mismatch");
		$finish;
	end
endmodule
